// File: src/bitstream_reader_exp_golomb_core_macros.svh
// Assertion macros for the bitstream reader.
`ifndef BITSTREAM_READER_EXP_GOLOMB_CORE_MACROS_SVH
`define BITSTREAM_READER_EXP_GOLOMB_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BRE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bre assertion failed");
`define BRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bre assertion failed");
`else
`define BRE_ASSERT_SAME(label, ante, cons)
`define BRE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: src/bre_pkg.sv
// Shared types, codes and helpers for the bitstream reader.
package bre_pkg;

    localparam int BUFFER_BYTES = 4096;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int LOAD_W       = $clog2(BUFFER_BYTES + 1);
    localparam int BIT_W        = LOAD_W + 3;

    typedef logic [3:0] req_code_t;
    localparam req_code_t REQ_LOAD      = 4'd0;
    localparam req_code_t REQ_CLEAR     = 4'd1;
    localparam req_code_t REQ_READ_BITS = 4'd2;
    localparam req_code_t REQ_READ_BIT  = 4'd3;
    localparam req_code_t REQ_SKIP      = 4'd4;
    localparam req_code_t REQ_UE        = 4'd5;
    localparam req_code_t REQ_SE        = 4'd6;
    localparam req_code_t REQ_NS        = 4'd7;
    localparam req_code_t REQ_LEB       = 4'd8;

    localparam logic [6:0]  MAX_READ_BITS   = 7'd64;
    localparam logic [5:0]  UE_MAX_ZEROS    = 6'd32;
    localparam logic [31:0] NS_MAX          = 32'h8000_0000;
    localparam logic [3:0]  LEB_MAX_BYTES   = 4'd10;
    localparam logic [7:0]  LEB_PAYLOAD     = 8'h7f;
    localparam logic [7:0]  LEB_LAST_OK     = 8'h01;
    localparam logic [5:0]  LEB_STEP        = 6'd7;
    localparam logic [6:0]  BYTE_BITS       = 7'd8;

    typedef struct packed {
        req_code_t   kind;
        logic [7:0]  data_byte;
        logic [6:0]  nbits;
        logic [31:0] alphabet_size;
    } req_t;

    typedef struct packed {
        logic [63:0] value;
        logic [31:0] signed_value;
        logic        ok;
        logic [15:0] remaining_bits;
    } res_t;

    // number of significant bits in a byte
    function automatic logic [3:0] width8(input logic [7:0] b);
        logic [3:0] w;
        w = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                w = 4'(i + 1);
            end
        end
        return w;
    endfunction

    // leading zeros of a byte, 8 when zero
    function automatic logic [3:0] lead_zeros8(input logic [7:0] b);
        logic [3:0] lz;
        lz = 4'd8;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                lz = 4'(7 - i);
            end
        end
        return lz;
    endfunction

endpackage

// File: src/bre_ram.sv
// Byte store: one write port, one read port with registered data.
module bre_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/bre_seq.sv
// Request sequencer: walks store bytes and decodes raw, Exp-Golomb, truncated and LEB128 reads.
`include "bitstream_reader_exp_golomb_core_macros.svh"
module bre_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  bre_pkg::req_t              req,
    output logic                       idle,
    input  logic                       out_free,
    output logic                       done,
    output bre_pkg::res_t              res,
    output logic                       mem_wr_en,
    output logic [bre_pkg::ADDR_W-1:0] mem_wr_addr,
    output logic [7:0]                 mem_wr_data,
    output logic                       mem_rd_en,
    output logic [bre_pkg::ADDR_W-1:0] mem_rd_addr,
    input  logic [7:0]                 mem_rd_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHUNK,
        ST_UE_ZERO,
        ST_UE_DONE,
        ST_NS_WIDTH,
        ST_NS_SETUP,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        PU_BITS,
        PU_UE_TAIL,
        PU_NS_MAIN,
        PU_NS_EXTRA,
        PU_LEB
    } purpose_t;

    state_t                      state_reg, state_next;
    purpose_t                    purpose_reg, purpose_next;
    logic [bre_pkg::LOAD_W-1:0]  loaded_reg, loaded_next;
    logic [bre_pkg::BIT_W-1:0]   consumed_reg, consumed_next;
    logic                        err_reg, err_next;
    logic [6:0]                  need_reg, need_next;
    logic [63:0]                 acc_reg, acc_next;
    logic [4:0]                  zeros_reg, zeros_next;
    logic                        is_se_reg, is_se_next;
    logic [31:0]                 ns_n_reg, ns_n_next;
    logic [1:0]                  ns_j_reg, ns_j_next;
    logic [5:0]                  ns_w_reg, ns_w_next;
    logic [31:0]                 small_reg, small_next;
    logic [63:0]                 leb_acc_reg, leb_acc_next;
    logic [3:0]                  leb_cnt_reg, leb_cnt_next;
    logic [5:0]                  leb_sh_reg, leb_sh_next;
    logic [63:0]                 val_reg, val_next;

    logic [bre_pkg::BIT_W-1:0]   left;
    logic [bre_pkg::BIT_W-1:0]   rd_pos;
    logic [2:0]                  offset;
    logic [3:0]                  avail;
    logic [3:0]                  k;
    logic [7:0]                  shifted;
    logic [7:0]                  mask;
    logic [63:0]                 acc_new;
    logic [bre_pkg::BIT_W-1:0]   cons_k;
    logic [6:0]                  need_left;
    logic [bre_pkg::BIT_W-1:0]   left_k;
    logic [7:0]                  seg;
    logic [3:0]                  lz;
    logic                        found;
    logic [5:0]                  zsum_found;
    logic [5:0]                  zsum_all;
    logic [7:0]                  leb_b;
    logic [63:0]                 leb_val;
    logic [3:0]                  leb_cnt_new;
    logic [6:0]                  cnt;
    logic [7:0]                  ns_sel;
    logic [5:0]                  ns_base;
    logic [31:0]                 sval;

    assign left      = {loaded_reg, 3'b000} - consumed_reg;
    assign offset    = consumed_reg[2:0];
    assign avail     = 4'd8 - {1'b0, offset};
    assign k         = (need_reg < {3'b000, avail}) ? need_reg[3:0] : avail;
    assign shifted   = mem_rd_data >> (avail - k);
    assign mask      = 8'((9'd1 << k) - 9'd1);
    assign acc_new   = (acc_reg << k) | {56'd0, shifted & mask};
    assign cons_k    = consumed_reg + bre_pkg::BIT_W'(k);
    assign need_left = need_reg - {3'b000, k};
    assign left_k    = left - bre_pkg::BIT_W'(k);

    assign seg        = mem_rd_data << offset;
    assign lz         = bre_pkg::lead_zeros8(seg);
    assign found      = lz < avail;
    assign zsum_found = {1'b0, zeros_reg} + {2'b00, lz};
    assign zsum_all   = {1'b0, zeros_reg} + {2'b00, avail};

    assign leb_b       = acc_new[7:0];
    assign leb_val     = leb_acc_reg | ({56'd0, leb_b & bre_pkg::LEB_PAYLOAD} << leb_sh_reg);
    assign leb_cnt_new = leb_cnt_reg + 4'd1;

    assign cnt = (req.kind == bre_pkg::REQ_READ_BIT) ? 7'd1 : req.nbits;

    always_comb
    begin
        case (ns_j_reg)
            2'd0:
            begin
                ns_sel  = ns_n_reg[31:24];
                ns_base = 6'd24;
            end
            2'd1:
            begin
                ns_sel  = ns_n_reg[23:16];
                ns_base = 6'd16;
            end
            2'd2:
            begin
                ns_sel  = ns_n_reg[15:8];
                ns_base = 6'd8;
            end
            default:
            begin
                ns_sel  = ns_n_reg[7:0];
                ns_base = 6'd0;
            end
        endcase
    end

    always_comb
    begin
        if (val_reg[0])
        begin
            sval = 32'(({1'b0, val_reg[31:0]} + 33'd1) >> 1);
        end
        else
        begin
            sval = 32'd0 - {1'b0, val_reg[31:1]};
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        purpose_next  = purpose_reg;
        loaded_next   = loaded_reg;
        consumed_next = consumed_reg;
        err_next      = err_reg;
        need_next     = need_reg;
        acc_next      = acc_reg;
        zeros_next    = zeros_reg;
        is_se_next    = is_se_reg;
        ns_n_next     = ns_n_reg;
        ns_j_next     = ns_j_reg;
        ns_w_next     = ns_w_reg;
        small_next    = small_reg;
        leb_acc_next  = leb_acc_reg;
        leb_cnt_next  = leb_cnt_reg;
        leb_sh_next   = leb_sh_reg;
        val_next      = val_reg;
        mem_wr_en     = 1'b0;
        mem_rd_en     = 1'b0;
        rd_pos        = consumed_reg;
        done          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    val_next   = 64'd0;
                    is_se_next = 1'b0;
                    state_next = ST_FINISH;
                    case (req.kind)
                        bre_pkg::REQ_LOAD:
                        begin
                            if (loaded_reg < bre_pkg::LOAD_W'(bre_pkg::BUFFER_BYTES))
                            begin
                                mem_wr_en   = 1'b1;
                                loaded_next = loaded_reg + bre_pkg::LOAD_W'(1);
                            end
                        end
                        bre_pkg::REQ_CLEAR:
                        begin
                            loaded_next   = '0;
                            consumed_next = '0;
                            err_next      = 1'b0;
                        end
                        bre_pkg::REQ_READ_BITS, bre_pkg::REQ_READ_BIT:
                        begin
                            if (err_reg || cnt > bre_pkg::MAX_READ_BITS
                                || left < bre_pkg::BIT_W'(cnt))
                            begin
                                err_next = 1'b1;
                            end
                            else if (cnt != 7'd0)
                            begin
                                need_next    = cnt;
                                acc_next     = 64'd0;
                                purpose_next = PU_BITS;
                                mem_rd_en    = 1'b1;
                                state_next   = ST_CHUNK;
                            end
                        end
                        bre_pkg::REQ_SKIP:
                        begin
                            if (err_reg || left < bre_pkg::BIT_W'(req.nbits))
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                consumed_next = consumed_reg
                                                + bre_pkg::BIT_W'(req.nbits);
                            end
                        end
                        bre_pkg::REQ_UE, bre_pkg::REQ_SE:
                        begin
                            is_se_next = (req.kind == bre_pkg::REQ_SE);
                            if (!err_reg)
                            begin
                                if (left == '0)
                                begin
                                    err_next = 1'b1;
                                end
                                else
                                begin
                                    zeros_next = 5'd0;
                                    mem_rd_en  = 1'b1;
                                    state_next = ST_UE_ZERO;
                                end
                            end
                        end
                        bre_pkg::REQ_NS:
                        begin
                            if (err_reg || req.alphabet_size == 32'd0
                                || req.alphabet_size > bre_pkg::NS_MAX)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                ns_n_next  = req.alphabet_size;
                                ns_j_next  = 2'd0;
                                state_next = ST_NS_WIDTH;
                            end
                        end
                        bre_pkg::REQ_LEB:
                        begin
                            if (!err_reg)
                            begin
                                if (left < bre_pkg::BIT_W'(bre_pkg::BYTE_BITS))
                                begin
                                    err_next = 1'b1;
                                end
                                else
                                begin
                                    need_next    = bre_pkg::BYTE_BITS;
                                    acc_next     = 64'd0;
                                    leb_acc_next = 64'd0;
                                    leb_cnt_next = 4'd0;
                                    leb_sh_next  = 6'd0;
                                    purpose_next = PU_LEB;
                                    mem_rd_en    = 1'b1;
                                    state_next   = ST_CHUNK;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_CHUNK:
            begin
                consumed_next = cons_k;
                acc_next      = acc_new;
                need_next     = need_left;
                rd_pos        = cons_k;
                mem_rd_en     = 1'b1;
                if (need_left == 7'd0)
                begin
                    state_next = ST_FINISH;
                    case (purpose_reg)
                        PU_BITS:
                        begin
                            val_next = acc_new;
                        end
                        PU_UE_TAIL:
                        begin
                            state_next = ST_UE_DONE;
                        end
                        PU_NS_MAIN:
                        begin
                            if (acc_new[31:0] < small_reg)
                            begin
                                val_next = {32'd0, acc_new[31:0]};
                            end
                            else if (left_k == '0)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                need_next    = 7'd1;
                                purpose_next = PU_NS_EXTRA;
                                state_next   = ST_CHUNK;
                            end
                        end
                        PU_NS_EXTRA:
                        begin
                            val_next = {32'd0, acc_new[31:0] - small_reg};
                        end
                        PU_LEB:
                        begin
                            leb_acc_next = leb_val;
                            leb_cnt_next = leb_cnt_new;
                            leb_sh_next  = leb_sh_reg + bre_pkg::LEB_STEP;
                            if (leb_cnt_new < bre_pkg::LEB_MAX_BYTES && leb_b[7])
                            begin
                                if (left_k < bre_pkg::BIT_W'(bre_pkg::BYTE_BITS))
                                begin
                                    err_next = 1'b1;
                                end
                                else
                                begin
                                    need_next  = bre_pkg::BYTE_BITS;
                                    acc_next   = 64'd0;
                                    state_next = ST_CHUNK;
                                end
                            end
                            else
                            begin
                                if (leb_cnt_new == bre_pkg::LEB_MAX_BYTES
                                    && leb_b > bre_pkg::LEB_LAST_OK)
                                begin
                                    err_next = 1'b1;
                                end
                                val_next = leb_val;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_UE_ZERO:
            begin
                if (found)
                begin
                    if (zsum_found >= bre_pkg::UE_MAX_ZEROS)
                    begin
                        err_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        consumed_next = consumed_reg + bre_pkg::BIT_W'(lz)
                                        + bre_pkg::BIT_W'(1);
                        zeros_next    = zsum_found[4:0];
                        rd_pos        = consumed_next;
                        if (zsum_found == 6'd0)
                        begin
                            val_next   = 64'd0;
                            state_next = ST_FINISH;
                        end
                        else if (left - bre_pkg::BIT_W'(lz) - bre_pkg::BIT_W'(1)
                                 < bre_pkg::BIT_W'(zsum_found))
                        begin
                            err_next   = 1'b1;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            need_next    = {1'b0, zsum_found};
                            acc_next     = 64'd0;
                            purpose_next = PU_UE_TAIL;
                            mem_rd_en    = 1'b1;
                            state_next   = ST_CHUNK;
                        end
                    end
                end
                else
                begin
                    if (zsum_all >= bre_pkg::UE_MAX_ZEROS
                        || left == bre_pkg::BIT_W'(avail))
                    begin
                        err_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        consumed_next = consumed_reg + bre_pkg::BIT_W'(avail);
                        zeros_next    = zsum_all[4:0];
                        rd_pos        = consumed_next;
                        mem_rd_en     = 1'b1;
                    end
                end
            end

            ST_UE_DONE:
            begin
                val_next   = {32'd0, (32'd1 << zeros_reg) + acc_reg[31:0] - 32'd1};
                state_next = ST_FINISH;
            end

            ST_NS_WIDTH:
            begin
                if (ns_sel != 8'd0)
                begin
                    ns_w_next  = ns_base + {2'b00, bre_pkg::width8(ns_sel)};
                    state_next = ST_NS_SETUP;
                end
                else
                begin
                    ns_j_next = ns_j_reg + 2'd1;
                end
            end

            ST_NS_SETUP:
            begin
                small_next = 32'((33'd1 << ns_w_reg) - {1'b0, ns_n_reg});
                state_next = ST_FINISH;
                if (ns_w_reg == 6'd1)
                begin
                    val_next = 64'd0;
                end
                else if (left < bre_pkg::BIT_W'(ns_w_reg - 6'd1))
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    need_next    = 7'(ns_w_reg - 6'd1);
                    acc_next     = 64'd0;
                    purpose_next = PU_NS_MAIN;
                    mem_rd_en    = 1'b1;
                    state_next   = ST_CHUNK;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            purpose_reg  <= PU_BITS;
            loaded_reg   <= '0;
            consumed_reg <= '0;
            err_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            purpose_reg  <= purpose_next;
            loaded_reg   <= loaded_next;
            consumed_reg <= consumed_next;
            err_reg      <= err_next;
            need_reg     <= need_next;
            acc_reg      <= acc_next;
            zeros_reg    <= zeros_next;
            is_se_reg    <= is_se_next;
            ns_n_reg     <= ns_n_next;
            ns_j_reg     <= ns_j_next;
            ns_w_reg     <= ns_w_next;
            small_reg    <= small_next;
            leb_acc_reg  <= leb_acc_next;
            leb_cnt_reg  <= leb_cnt_next;
            leb_sh_reg   <= leb_sh_next;
            val_reg      <= val_next;
        end
    end

    assign idle        = (state_reg == ST_IDLE);
    assign mem_wr_addr = loaded_reg[bre_pkg::ADDR_W-1:0];
    assign mem_wr_data = req.data_byte;
    assign mem_rd_addr = rd_pos[bre_pkg::ADDR_W+2:3];

    assign res.value          = err_reg ? 64'd0 : val_reg;
    assign res.signed_value   = (err_reg || !is_se_reg) ? 32'd0 : sval;
    assign res.ok             = !err_reg;
    assign res.remaining_bits = err_reg ? 16'd0 : 16'(left);

    `BRE_ASSERT_SAME(a_consumed_in_range, !err_reg, consumed_reg <= {loaded_reg, 3'b000})
    `BRE_ASSERT_SAME(a_loaded_bound, 1'b1, loaded_reg <= bre_pkg::LOAD_W'(bre_pkg::BUFFER_BYTES))
    `BRE_ASSERT_SAME(a_chunk_has_work, state_reg == ST_CHUNK, need_reg != 7'd0)
    `BRE_ASSERT_NEXT(a_done_returns_idle, done, state_reg == ST_IDLE)

endmodule

// File: src/bitstream_reader_exp_golomb_core.sv
// Top level of the bitstream reader: stream ports, byte store and result register.
//
// Requests enter on the s_ group, one word per request; every request gives
// exactly one result word on the m_ group, in order. A request is taken only
// while the core is idle; its result sits in an output register, so the next
// request is taken while that result waits for m_tready.
// Load, clear, skip, unknown codes and any request that fails at once read no
// store byte. A raw read touches store bytes one after another (up to 9 for
// 64 bits). An Exp-Golomb read scans bytes for the leading one, then reads the
// tail bytes and forms the value. A truncated-binary read scans the alphabet
// size for its width, then reads the bytes it touches and, if needed, an extra
// bit. LEB128 reads each code byte, which may span two store bytes.
// The rate is set by the single read port of the byte store: one byte a cycle.
// Reset empties the buffer and clears the error flag; store contents stay
// undefined until loaded. If the receiver stalls, the finished result waits
// in the core until the output register frees, and no new request is taken.
module bitstream_reader_exp_golomb_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // data_byte[7:0], nbits[14:8], alphabet_size[46:15]
    input  logic [3:0]   s_tuser,   // req_type[3:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // value[63:0], signed_value[95:64], remaining_bits[111:96]
    output logic [0:0]   m_tuser    // ok[0]
);

    bre_pkg::req_t req;
    bre_pkg::res_t res;
    bre_pkg::res_t res_reg;
    logic          m_tvalid_reg;
    logic          idle;
    logic          done;
    logic          out_free;
    logic          mem_wr_en;
    logic [bre_pkg::ADDR_W-1:0] mem_wr_addr;
    logic [7:0]    mem_wr_data;
    logic          mem_rd_en;
    logic [bre_pkg::ADDR_W-1:0] mem_rd_addr;
    logic [7:0]    mem_rd_data;

    assign req.kind          = s_tuser;
    assign req.data_byte     = s_tdata[7:0];
    assign req.nbits         = s_tdata[14:8];
    assign req.alphabet_size = s_tdata[46:15];

    assign s_tready = idle;
    assign out_free = !m_tvalid_reg || m_tready;

    bre_ram #(
        .DEPTH (bre_pkg::BUFFER_BYTES),
        .WIDTH (8)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    bre_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (s_tvalid && s_tready),
        .req         (req),
        .idle        (idle),
        .out_free    (out_free),
        .done        (done),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (done)
            begin
                m_tvalid_reg <= 1'b1;
                res_reg      <= res;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {res_reg.remaining_bits, res_reg.signed_value, res_reg.value};
    assign m_tuser  = res_reg.ok;

endmodule
